// ===== design/jtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick-to-mouse package
// Shared item types, register codes and width helpers.
// ----------------------------------------------------------------------------
package jtm_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int OFFSET_W    = 12;
  localparam int MARGIN_W    = 16;
  localparam int SCALE_W     = 12;
  localparam int MOVE_W      = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] REG_DEAD_MARGIN = 2'd1;
  localparam logic [1:0] REG_MOVE_SCALE  = 2'd2;

  localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST = 12'd2048;
  localparam logic [MARGIN_W-1:0] DEAD_MARGIN_RST = 16'd0;
  localparam logic [SCALE_W-1:0]  MOVE_SCALE_RST  = 12'd1;

  localparam logic [MOVE_W-1:0] MOVE_MAX = 8'h7f;
  localparam logic [MOVE_W-1:0] MOVE_MIN = 8'h80;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [MOVE_W-1:0] move_x;
    logic signed [MOVE_W-1:0] move_y;
  } out_item_t;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
  } queue_entry_t;

  // Per-cycle commands from the sequencer to both axis lanes.
  typedef struct packed {
    logic write;
    logic read;
    logic clear;
    logic accum;
    logic adjust;
    logic dead;
    logic load;
    logic step;
  } lane_ctl_t;

  function automatic int addr_width(input int count);
    int w;
    w = (count > 1) ? $clog2(count) : 1;
    return w;
  endfunction

  // Signed width that holds the offset-corrected sum, the dead margin and
  // the rounding term without overflow.
  function automatic int sum_width(input int count, input int bits);
    int widest;
    int raw;
    widest = (bits > SAMPLE_W) ? bits : SAMPLE_W;
    raw    = widest + $clog2(count) + 2;
    return (raw > MARGIN_W + 2) ? raw : MARGIN_W + 2;
  endfunction

endpackage

// ===== design/joystick_to_mouse_delta_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick-to-mouse delta top level
// Averages ring-buffered joystick samples per axis into saturated mouse moves.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid_i/in_stall_o    in_data_i   (in_item_t)
//   out       source     out_valid_o/out_stall_i  out_data_o  (out_item_t)
//   config    APB slave  psel/penable/pready      paddr/pwdata/prdata
//
// Sample requests write the rings. Tick requests walk the rings one entry per
// cycle and then run the one-bit-per-cycle divider. The sum width SUM_W is
// at least 18. Rings read as zero after reset through per-entry valid bits.
// The two-entry queue keeps accepting, until it is full, while a tick is
// worked on or a result waits on out_stall_i.
// ----------------------------------------------------------------------------
module joystick_to_mouse_delta_top #(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  jtm_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output jtm_pkg::out_item_t             out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [jtm_pkg::PADDR_W-1:0]    paddr,
  input  logic [jtm_pkg::PDATA_W-1:0]    pwdata,
  output logic [jtm_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int AddrW = jtm_pkg::addr_width(SAMPLE_COUNT);

  logic [jtm_pkg::OFFSET_W-1:0] zero_offset_q;
  logic [jtm_pkg::MARGIN_W-1:0] dead_margin_q;
  logic [jtm_pkg::SCALE_W-1:0]  move_scale_q;
  logic                         cfg_wr;
  logic [1:0]                   reg_idx;

  logic                         q_valid;
  logic                         q_pop;
  jtm_pkg::queue_entry_t        q_entry;
  jtm_pkg::lane_ctl_t           lane_ctl;
  logic [AddrW-1:0]             wr_addr;
  logic [AddrW-1:0]             rd_addr;
  logic signed [jtm_pkg::MOVE_W-1:0] move_x;
  logic signed [jtm_pkg::MOVE_W-1:0] move_y;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= jtm_pkg::ZERO_OFFSET_RST;
      dead_margin_q <= jtm_pkg::DEAD_MARGIN_RST;
      move_scale_q  <= jtm_pkg::MOVE_SCALE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        jtm_pkg::REG_ZERO_OFFSET: zero_offset_q <= pwdata[jtm_pkg::OFFSET_W-1:0];
        jtm_pkg::REG_DEAD_MARGIN: dead_margin_q <= pwdata[jtm_pkg::MARGIN_W-1:0];
        jtm_pkg::REG_MOVE_SCALE:  move_scale_q  <= pwdata[jtm_pkg::SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jtm_pkg::REG_ZERO_OFFSET: prdata = jtm_pkg::PDATA_W'(zero_offset_q);
      jtm_pkg::REG_DEAD_MARGIN: prdata = jtm_pkg::PDATA_W'(dead_margin_q);
      jtm_pkg::REG_MOVE_SCALE:  prdata = jtm_pkg::PDATA_W'(move_scale_q);
      default:                  prdata = '0;
    endcase
  end

  jtm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  jtm_axis #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_axis_x (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (lane_ctl),
    .wr_addr_i     (wr_addr),
    .rd_addr_i     (rd_addr),
    .wr_data_i     (q_entry.x_sample),
    .zero_offset_i (zero_offset_q),
    .dead_margin_i (dead_margin_q),
    .move_scale_i  (move_scale_q),
    .move_o        (move_x)
  );

  jtm_axis #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_axis_y (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (lane_ctl),
    .wr_addr_i     (wr_addr),
    .rd_addr_i     (rd_addr),
    .wr_data_i     (q_entry.y_sample),
    .zero_offset_i (zero_offset_q),
    .dead_margin_i (dead_margin_q),
    .move_scale_i  (move_scale_q),
    .move_o        (move_y)
  );

  jtm_back #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .ctl_o       (lane_ctl),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr),
    .move_x_i    (move_x),
    .move_y_i    (move_y),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/jtm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick-to-mouse front end
// Accepts input requests, classifies them into sample or tick operations and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module jtm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  jtm_pkg::in_item_t      in_data_i,
  output logic                   q_valid_o,
  output jtm_pkg::queue_entry_t  q_entry_o,
  input  logic                   q_pop_i
);

  localparam int Depth = jtm_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  jtm_pkg::queue_entry_t ent_q [Depth];
  jtm_pkg::queue_entry_t new_entry;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  always_comb begin
    new_entry.op       = in_data_i.command ? jtm_pkg::OP_TICK : jtm_pkg::OP_SAMPLE;
    new_entry.x_sample = in_data_i.x_sample;
    new_entry.y_sample = in_data_i.y_sample;
  end

  assign in_stall_o = (cnt_q == CntW'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_entry_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

// ===== design/jtm_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick-to-mouse axis lane
// Sample ring for one axis plus the datapath that sums it, removes the zero offset,
// applies the dead zone and rounding, divides serially and saturates the move.
// ----------------------------------------------------------------------------
module jtm_axis #(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  jtm_pkg::lane_ctl_t                            ctl_i,
  input  logic [jtm_pkg::addr_width(SAMPLE_COUNT)-1:0]  wr_addr_i,
  input  logic [jtm_pkg::addr_width(SAMPLE_COUNT)-1:0]  rd_addr_i,
  input  logic [jtm_pkg::SAMPLE_W-1:0]                  wr_data_i,
  input  logic [jtm_pkg::OFFSET_W-1:0]                  zero_offset_i,
  input  logic [jtm_pkg::MARGIN_W-1:0]                  dead_margin_i,
  input  logic [jtm_pkg::SCALE_W-1:0]                   move_scale_i,
  output logic signed [jtm_pkg::MOVE_W-1:0]             move_o
);

  localparam int SumW = jtm_pkg::sum_width(SAMPLE_COUNT, SAMPLE_BITS);
  localparam int DvsW = jtm_pkg::SCALE_W + $clog2(SAMPLE_COUNT);
  localparam int MoveW = jtm_pkg::MOVE_W;

  logic [SAMPLE_BITS-1:0]  ring_q [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0] vld_q;
  logic [SAMPLE_BITS-1:0]  rd_data_q;
  logic                    rd_vld_q;

  logic signed [SumW-1:0]  acc_q, acc_d;
  logic [SumW-1:0]         dnd_q;
  logic [DvsW-1:0]         rem_q;
  logic [DvsW-1:0]         dvs_q;
  logic                    neg_q;

  logic [SAMPLE_BITS-1:0]  rd_val;
  logic [SumW-1:0]         off_n;
  logic [SumW-1:0]         acc_mag;
  logic                    in_dead;
  logic [jtm_pkg::SCALE_W-1:0] scale_eff;
  logic [SumW-1:0]         half;
  logic [DvsW:0]           trial;
  logic                    fits;
  logic [MoveW-1:0]        q_lo;

  // Ring storage; entries not yet written read as zero through the valid bits.
  always_ff @(posedge clk_i) begin
    if (ctl_i.write) begin
      ring_q[wr_addr_i] <= SAMPLE_BITS'(wr_data_i);
    end
    if (ctl_i.read) begin
      rd_data_q <= ring_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.write) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.read) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    rd_val    = rd_vld_q ? rd_data_q : '0;
    off_n     = SumW'(zero_offset_i) * SumW'(SAMPLE_COUNT);
    acc_mag   = acc_q[SumW-1] ? SumW'(-acc_q) : SumW'(acc_q);
    in_dead   = (acc_mag <= SumW'(dead_margin_i));
    scale_eff = (move_scale_i == '0) ? jtm_pkg::SCALE_W'(1) : move_scale_i;
    half      = SumW'(scale_eff >> 1);
    trial     = {rem_q, dnd_q[SumW-1]};
    fits      = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.accum) begin
      acc_d = acc_q + $signed(SumW'(rd_val));
    end else if (ctl_i.adjust) begin
      acc_d = acc_q - $signed(off_n);
    end else if (ctl_i.dead) begin
      acc_d = (in_dead ? '0 : acc_q) + $signed(half);
    end
  end

  // Dividing by scale and then by the ring size equals one division by their
  // product for the magnitude; the sign is put back afterwards.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.adjust) begin
      dvs_q <= DvsW'(scale_eff) * DvsW'(SAMPLE_COUNT);
    end
    if (ctl_i.load) begin
      neg_q <= acc_q[SumW-1];
      dnd_q <= acc_mag;
      rem_q <= '0;
    end else if (ctl_i.step) begin
      dnd_q <= {dnd_q[SumW-2:0], fits};
      rem_q <= fits ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
    end
  end

  assign q_lo = dnd_q[MoveW-1:0];

  always_comb begin
    if (neg_q) begin
      move_o = (dnd_q > SumW'(128)) ? jtm_pkg::MOVE_MIN : MoveW'(~q_lo + 1'b1);
    end else begin
      move_o = (dnd_q > SumW'(127)) ? jtm_pkg::MOVE_MAX : q_lo;
    end
  end

endmodule

// ===== design/jtm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick-to-mouse back end
// Sequencer that drains the queue: sample requests write the rings, tick
// requests walk the rings, run the lane arithmetic and load the output.
// ----------------------------------------------------------------------------
module jtm_back #(
  parameter int SAMPLE_COUNT = 8,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          q_valid_i,
  input  jtm_pkg::queue_entry_t                         q_entry_i,
  output logic                                          q_pop_o,
  output jtm_pkg::lane_ctl_t                            ctl_o,
  output logic [jtm_pkg::addr_width(SAMPLE_COUNT)-1:0]  wr_addr_o,
  output logic [jtm_pkg::addr_width(SAMPLE_COUNT)-1:0]  rd_addr_o,
  input  logic signed [jtm_pkg::MOVE_W-1:0]             move_x_i,
  input  logic signed [jtm_pkg::MOVE_W-1:0]             move_y_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output jtm_pkg::out_item_t                            out_data_o
);

  localparam int AddrW   = jtm_pkg::addr_width(SAMPLE_COUNT);
  localparam int SumW    = jtm_pkg::sum_width(SAMPLE_COUNT, SAMPLE_BITS);
  localparam int CntW    = $clog2(SAMPLE_COUNT + 1);
  localparam int DivCntW = $clog2(SumW);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_ADJ  = 3'd2;
  localparam logic [2:0] S_DZ   = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [AddrW-1:0]   slot_q, slot_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               rd_pend_q;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  jtm_pkg::out_item_t out_data_q;

  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign wr_addr_o   = slot_q;
  assign rd_addr_o   = cnt_q[AddrW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    div_cnt_d = div_cnt_q;
    out_load  = 1'b0;
    ctl_o     = '0;
    ctl_o.accum = rd_pend_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.op == jtm_pkg::OP_TICK) begin
            ctl_o.clear = 1'b1;
            cnt_d       = '0;
            state_d     = S_SUM;
          end else begin
            ctl_o.write = 1'b1;
            slot_d = (slot_q == AddrW'(SAMPLE_COUNT - 1)) ? '0 : slot_q + 1'b1;
          end
        end
      end
      S_SUM: begin
        // Reads are issued one per cycle; each datum is summed in the next cycle.
        if (cnt_q < CntW'(SAMPLE_COUNT)) begin
          ctl_o.read = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end else begin
          state_d = S_ADJ;
        end
      end
      S_ADJ: begin
        ctl_o.adjust = 1'b1;
        state_d      = S_DZ;
      end
      S_DZ: begin
        ctl_o.dead = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        ctl_o.load = 1'b1;
        div_cnt_d  = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        ctl_o.step = 1'b1;
        div_cnt_d  = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(SumW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      cnt_q       <= cnt_d;
      div_cnt_q   <= div_cnt_d;
      rd_pend_q   <= ctl_o.read;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.move_x <= move_x_i;
      out_data_q.move_y <= move_y_i;
    end
  end

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output became valid without a finished tick");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(SAMPLE_COUNT))
    else $error("ring read counter beyond ring size");

  a_last_summed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) && (cnt_q == CntW'(SAMPLE_COUNT)) |-> rd_pend_q)
    else $error("last ring entry not summed before offset correction");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |=> (state_q == S_DIV) && (div_cnt_q == '0))
    else $error("divider did not start from step zero");

endmodule
